// File: hdl/lrt_pkg.sv
package lrt_pkg;

    localparam int ID_W      = 16;
    localparam int FIELD_W   = 12;
    localparam int CLASS_W   = 8;
    localparam int MISS_W    = 9;
    localparam int OCC_W     = 5;
    localparam int MLIM_W    = 8;
    localparam int DLIM_W    = 12;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MISSING_LIMIT  = 1'b0,
        REG_DISTANCE_LIMIT = 1'b1
    } t_cfg_reg;

    localparam logic [MLIM_W-1:0] MISSING_LIMIT_RST  = 8'd30;
    localparam logic [DLIM_W-1:0] DISTANCE_LIMIT_RST = 12'd50;
    localparam logic [MISS_W-1:0] MISS_MAX           = '1;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic store;
        logic rd;
        logic rd_next;
        logic tick_ev;
        logic sq;
        logic hit;
        logic next;
        logic shift_wr;
        logic tick_end;
        logic q_end;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic walk_end;
        logic shift_end;
        logic match;
    } t_dp_stat;

endpackage

// File: hdl/lrt_ifs.sv
interface lrt_in_if;
    import lrt_pkg::*;
    logic                valid;
    logic                ready;
    t_cmd                cmd;
    logic [ID_W-1:0]     lost_id;
    logic [FIELD_W-1:0]  box_x;
    logic [FIELD_W-1:0]  box_y;
    logic [FIELD_W-1:0]  box_w;
    logic [FIELD_W-1:0]  box_h;
    logic [CLASS_W-1:0]  obj_class;

    modport source (output valid, cmd, lost_id, box_x, box_y, box_w, box_h, obj_class,
                    input ready);
    modport sink   (input valid, cmd, lost_id, box_x, box_y, box_w, box_h, obj_class,
                    output ready);
endinterface

interface lrt_out_if;
    import lrt_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ID_W-1:0]   match_id;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, found, match_id, dropped, occupancy, input ready);
    modport sink   (input valid, found, match_id, dropped, occupancy, output ready);
endinterface

interface lrt_cfg_if;
    import lrt_pkg::*;
    logic               valid;
    logic               ready;
    t_cfg_reg           index;
    logic [DLIM_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/lost_track_recovery_table.sv
// Lost track recovery table.
// Input channel i_in: one word per command (store, tick, query, no-op).
// Output channel o_out: exactly one result word per input word, in order.
// Config channel i_cfg: index 0 missing_limit, index 1 distance_limit;
//   always ready, write only while the block is idle.
// One item at a time; entries walked one per step through a single-port
// table memory (one write, one registered read per cycle):
//   store         : accept, table write, result load
//   no-op         : accept, result load
//   tick          : each of the N entries held read, aged, kept or dropped
//   query miss    : per entry a read, squared distances, a compare
//   query hit     : walk to hit at k (oldest is 0), later entries moved down
// The input is ready again the cycle after a result is loaded, so a new
// word is taken while the previous result still waits in the output
// register.
// If the receiver stalls with a result waiting, the next item finishes its
// work and then holds until the output register is free.
// Reset (synchronous, active low): table emptied (occupancy zero), limits
// return to 30 frames and 50 pixels; no clearing pass is needed.
module lost_track_recovery_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrt_in_if.sink    i_in,
    lrt_out_if.source o_out,
    lrt_cfg_if.sink   i_cfg
);
    import lrt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // config writes land directly in the datapath limit registers
    assign i_cfg.ready = 1'b1;

    lrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_lost_id   (i_in.lost_id),
        .i_box_x     (i_in.box_x),
        .i_box_y     (i_in.box_y),
        .i_box_w     (i_in.box_w),
        .i_box_h     (i_in.box_h),
        .i_obj_class (i_in.obj_class),
        .o_found     (o_out.found),
        .o_match_id  (o_out.match_id),
        .o_dropped   (o_out.dropped),
        .o_occupancy (o_out.occupancy)
    );

endmodule

// File: hdl/lrt_ctrl.sv
module lrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lrt_pkg::t_cmd     i_in_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lrt_pkg::t_dp_stat i_stat,
    output lrt_pkg::t_dp_cmd  o_cmd
);
    import lrt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_RD,
        S_TEV,
        S_SQ,
        S_CMP,
        S_SRD,
        S_SWR,
        S_TEND,
        S_QEND,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_mode, n_mode;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_mode       = i_in_cmd;
                    case (i_in_cmd)
                        CMD_STORE: n_state = S_STORE;
                        CMD_TICK:  n_state = S_RD;
                        CMD_QUERY: n_state = S_RD;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_FIN;
            end
            S_RD: begin
                if (i_stat.walk_end) begin
                    n_state = (r_mode == CMD_TICK) ? S_TEND : S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = (r_mode == CMD_TICK) ? S_TEV : S_SQ;
                end
            end
            S_TEV: begin
                o_cmd.tick_ev = 1'b1;
                n_state       = S_RD;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_SRD;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_SRD: begin
                if (i_stat.shift_end) begin
                    n_state = S_QEND;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SRD;
            end
            S_TEND: begin
                o_cmd.tick_end = 1'b1;
                n_state        = S_FIN;
            end
            S_QEND: begin
                o_cmd.q_end = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= CMD_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/lrt_dp.sv
module lrt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrt_pkg::t_dp_cmd             i_cmd,
    output lrt_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_we,
    input  lrt_pkg::t_cfg_reg            i_cfg_idx,
    input  logic [lrt_pkg::DLIM_W-1:0]   i_cfg_data,
    input  logic [lrt_pkg::ID_W-1:0]     i_lost_id,
    input  logic [lrt_pkg::FIELD_W-1:0]  i_box_x,
    input  logic [lrt_pkg::FIELD_W-1:0]  i_box_y,
    input  logic [lrt_pkg::FIELD_W-1:0]  i_box_w,
    input  logic [lrt_pkg::FIELD_W-1:0]  i_box_h,
    input  logic [lrt_pkg::CLASS_W-1:0]  i_obj_class,
    output logic                         o_found,
    output logic [lrt_pkg::ID_W-1:0]     o_match_id,
    output logic                         o_dropped,
    output logic [lrt_pkg::OCC_W-1:0]    o_occupancy
);
    import lrt_pkg::*;

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CB     = COORD_BITS;
    localparam int CEN_W  = CB + 2;
    localparam int SQ_W   = 2 * CEN_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int LIM_W  = DLIM_W + 1;
    localparam int LIM2_W = 2 * LIM_W;
    localparam int CMP_W  = (SUM_W > LIM2_W) ? SUM_W : LIM2_W;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CB-1:0]      x;
        logic [CB-1:0]      y;
        logic [CB-1:0]      w;
        logic [CB-1:0]      h;
        logic [CLASS_W-1:0] cls;
        logic [MISS_W-1:0]  missed;
    } t_entry;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    t_entry r_q;

    logic [CNT_W-1:0]  r_count, r_idx, r_keep;
    logic [MLIM_W-1:0] r_miss_lim;
    logic [DLIM_W-1:0] r_dist_lim;
    logic [CEN_W-1:0]  r_qx, r_qy;
    logic [LIM2_W-1:0] r_lim2;
    logic [SQ_W-1:0]   r_dx2, r_dy2;
    logic              r_cls_eq;
    logic              r_found, r_dropped;
    logic [ID_W-1:0]   r_reuse;
    logic              r_o_found, r_o_dropped;
    logic [ID_W-1:0]   r_o_reuse;
    logic [OCC_W-1:0]  r_o_occ;

    logic [CB-1:0]     in_x, in_y, in_w, in_h;
    logic [CNT_W-1:0]  idx_p1;
    logic [MISS_W-1:0] m_inc;
    logic              keep_it;
    logic [CEN_W-1:0]  e_cx, e_cy, ax, ay;
    logic [SQ_W-1:0]   dx2, dy2;
    logic [LIM_W-1:0]  lim;
    logic [LIM2_W-1:0] lim2;
    logic [CMP_W-1:0]  dist2;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    t_entry            wr_data;

    // box fields cut to the coordinate width
    assign in_x = CB'(i_box_x);
    assign in_y = CB'(i_box_y);
    assign in_w = CB'(i_box_w);
    assign in_h = CB'(i_box_h);

    assign idx_p1  = r_idx + 1'b1;
    assign m_inc   = (r_rd.missed == MISS_MAX) ? r_rd.missed : r_rd.missed + 1'b1;
    assign keep_it = (m_inc <= MISS_W'(r_miss_lim));

    // doubled centres, absolute differences, squares
    assign e_cx = (CEN_W'(r_rd.x) << 1) + CEN_W'(r_rd.w);
    assign e_cy = (CEN_W'(r_rd.y) << 1) + CEN_W'(r_rd.h);
    assign ax   = (r_qx >= e_cx) ? (r_qx - e_cx) : (e_cx - r_qx);
    assign ay   = (r_qy >= e_cy) ? (r_qy - e_cy) : (e_cy - r_qy);
    assign dx2  = SQ_W'(ax) * SQ_W'(ax);
    assign dy2  = SQ_W'(ay) * SQ_W'(ay);
    assign lim  = {r_dist_lim, 1'b0};
    assign lim2 = LIM2_W'(lim) * LIM2_W'(lim);
    assign dist2 = CMP_W'(r_dx2) + CMP_W'(r_dy2);

    assign o_stat.full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_stat.walk_end  = (r_idx >= r_count);
    assign o_stat.shift_end = (idx_p1 >= r_count);
    assign o_stat.match     = r_cls_eq && (dist2 <= CMP_W'(r_lim2));

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = r_q;
        if (i_cmd.store) begin
            wr_en = !o_stat.full;
        end else if (i_cmd.tick_ev) begin
            wr_en          = keep_it;
            wr_addr        = r_keep[AW-1:0];
            wr_data        = r_rd;
            wr_data.missed = m_inc;
        end else if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[AW-1:0];
            wr_data = r_rd;
        end
    end

    assign rd_addr = i_cmd.rd ? r_idx[AW-1:0] : idx_p1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd || i_cmd.rd_next) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // table pointers and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_keep     <= '0;
            r_miss_lim <= MISSING_LIMIT_RST;
            r_dist_lim <= DISTANCE_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MISSING_LIMIT:  r_miss_lim <= i_cfg_data[MLIM_W-1:0];
                    REG_DISTANCE_LIMIT: r_dist_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_idx  <= '0;
                r_keep <= '0;
            end
            if (i_cmd.store && !o_stat.full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.tick_ev) begin
                r_idx <= idx_p1;
                if (keep_it) begin
                    r_keep <= r_keep + 1'b1;
                end
            end
            if (i_cmd.next || i_cmd.shift_wr) begin
                r_idx <= idx_p1;
            end
            if (i_cmd.tick_end) begin
                r_count <= r_keep;
            end
            if (i_cmd.q_end) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // item payload and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q.id     <= i_lost_id;
            r_q.x      <= in_x;
            r_q.y      <= in_y;
            r_q.w      <= in_w;
            r_q.h      <= in_h;
            r_q.cls    <= i_obj_class;
            r_q.missed <= '0;
            r_qx       <= (CEN_W'(in_x) << 1) + CEN_W'(in_w);
            r_qy       <= (CEN_W'(in_y) << 1) + CEN_W'(in_h);
            r_lim2     <= lim2;
            r_found    <= 1'b0;
            r_reuse    <= '0;
            r_dropped  <= 1'b0;
        end
        if (i_cmd.store && o_stat.full) begin
            r_dropped <= 1'b1;
        end
        if (i_cmd.sq) begin
            r_dx2    <= dx2;
            r_dy2    <= dy2;
            r_cls_eq <= (r_rd.cls == r_q.cls);
        end
        if (i_cmd.hit) begin
            r_found <= 1'b1;
            r_reuse <= r_rd.id;
        end
        if (i_cmd.load_out) begin
            r_o_found   <= r_found;
            r_o_reuse   <= r_reuse;
            r_o_dropped <= r_dropped;
            r_o_occ     <= OCC_W'(r_count);
        end
    end

    assign o_found     = r_o_found;
    assign o_match_id  = r_o_reuse;
    assign o_dropped   = r_o_dropped;
    assign o_occupancy = r_o_occ;

endmodule

// File: test/tb_lost_track_recovery_table.sv
`timescale 1ns / 100ps

// Lost track recovery table bench.
// Driver and receiver act on the falling edge, everything is sampled on the
// rising edge. Each word taken by the block is run through a local copy of the
// table and the predicted result is queued; every result word leaving the
// block is checked against the oldest prediction.
module tb_lost_track_recovery_table;
    import lrt_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        t_cmd                cmd;
        logic [ID_W-1:0]     lost_id;
        logic [FIELD_W-1:0]  box_x;
        logic [FIELD_W-1:0]  box_y;
        logic [FIELD_W-1:0]  box_w;
        logic [FIELD_W-1:0]  box_h;
        logic [CLASS_W-1:0]  obj_class;
    } t_track_word;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   match_id;
        logic              dropped;
        logic [OCC_W-1:0]  occupancy;
    } t_track_result;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [FIELD_W-1:0]  x;
        logic [FIELD_W-1:0]  y;
        logic [FIELD_W-1:0]  w;
        logic [FIELD_W-1:0]  h;
        logic [CLASS_W-1:0]  cls;
        logic [MISS_W-1:0]   missed;
    } t_lost_track;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // everything the bench drives, known from time zero
    logic                drv_valid = 1'b0;
    t_track_word         drv_word  = '0;
    logic                rcv_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    t_cfg_reg            cfg_index = REG_MISSING_LIMIT;
    logic [DLIM_W-1:0]   cfg_data  = '0;

    lrt_in_if  in_if();
    lrt_out_if out_if();
    lrt_cfg_if cfg_if();

    assign in_if.valid     = drv_valid;
    assign in_if.cmd       = drv_word.cmd;
    assign in_if.lost_id   = drv_word.lost_id;
    assign in_if.box_x     = drv_word.box_x;
    assign in_if.box_y     = drv_word.box_y;
    assign in_if.box_w     = drv_word.box_w;
    assign in_if.box_h     = drv_word.box_h;
    assign in_if.obj_class = drv_word.obj_class;
    assign out_if.ready    = rcv_ready;
    assign cfg_if.valid    = cfg_valid;
    assign cfg_if.index    = cfg_index;
    assign cfg_if.data     = cfg_data;

    lost_track_recovery_table #(
        .TABLE_DEPTH (DEPTH),
        .COORD_BITS  (FIELD_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // stimulus and scoreboard state
    t_track_word    pending_words[$];
    t_track_result  expected_results[$];
    t_track_word    recent_stores[$];   // boxes recently stored, for aimed queries
    int unsigned    words_offered = 0;
    int unsigned    words_taken   = 0;
    int unsigned    fail_count    = 0;
    int unsigned    src_idle_pct  = 0;
    int unsigned    rcv_idle_pct  = 0;

    // local copy of the table and its limits
    t_lost_track        lost_tracks[DEPTH];
    int unsigned        tracks_held    = 0;
    logic [MLIM_W-1:0]  lim_missing    = MISSING_LIMIT_RST;
    logic [DLIM_W-1:0]  lim_distance   = DISTANCE_LIMIT_RST;

    // Apply one word to the local table and return the result it causes.
    function automatic t_track_result track_table_step(t_track_word w);
        t_track_result r;
        int unsigned   keep;
        longint        qx;
        longint        qy;
        longint        dx;
        longint        dy;
        longint        lim2;
        r = '0;
        case (w.cmd)
            CMD_STORE: begin
                if (tracks_held < DEPTH) begin
                    lost_tracks[tracks_held] = '{id: w.lost_id, x: w.box_x, y: w.box_y,
                                                 w: w.box_w, h: w.box_h, cls: w.obj_class,
                                                 missed: '0};
                    tracks_held++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            CMD_TICK: begin
                // age every entry, compact the survivors in order
                keep = 0;
                for (int i = 0; i < tracks_held; i++) begin
                    if (lost_tracks[i].missed != MISS_MAX)
                        lost_tracks[i].missed++;
                    if (lost_tracks[i].missed <= lim_missing) begin
                        lost_tracks[keep] = lost_tracks[i];
                        keep++;
                    end
                end
                tracks_held = keep;
            end
            CMD_QUERY: begin
                // doubled centres keep the distance test exact
                qx   = 2 * longint'(w.box_x) + longint'(w.box_w);
                qy   = 2 * longint'(w.box_y) + longint'(w.box_h);
                lim2 = (2 * longint'(lim_distance)) * (2 * longint'(lim_distance));
                for (int i = 0; i < tracks_held; i++) begin
                    dx = qx - (2 * longint'(lost_tracks[i].x) + longint'(lost_tracks[i].w));
                    dy = qy - (2 * longint'(lost_tracks[i].y) + longint'(lost_tracks[i].h));
                    if (lost_tracks[i].cls == w.obj_class && dx * dx + dy * dy <= lim2) begin
                        r.found    = 1'b1;
                        r.match_id = lost_tracks[i].id;
                        for (int j = i; j + 1 < tracks_held; j++)
                            lost_tracks[j] = lost_tracks[j + 1];
                        tracks_held--;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(tracks_held);
        return r;
    endfunction

    function automatic t_track_word word_of(t_cmd cmd, int unsigned id, int unsigned x,
                                            int unsigned y, int unsigned w, int unsigned h,
                                            int unsigned cls);
        t_track_word t;
        t.cmd       = cmd;
        t.lost_id   = ID_W'(id);
        t.box_x     = FIELD_W'(x);
        t.box_y     = FIELD_W'(y);
        t.box_w     = FIELD_W'(w);
        t.box_h     = FIELD_W'(h);
        t.obj_class = CLASS_W'(cls);
        return t;
    endfunction

    // append a word to the sender's queue
    task automatic queue_word(t_track_word t);
        pending_words = {pending_words, t};
    endtask

    // shift a coordinate by up to +/- spread, clamped to the field range
    function automatic logic [FIELD_W-1:0] nudge(logic [FIELD_W-1:0] c, int unsigned spread);
        int v;
        v = int'(c);
        if ($urandom_range(1) == 1)
            v = v + int'($urandom_range(2 * spread)) - int'(spread);
        if (v < 0)
            v = 0;
        if (v > (1 << FIELD_W) - 1)
            v = (1 << FIELD_W) - 1;
        return FIELD_W'(v);
    endfunction

    // Random word: mostly stores and queries, most queries aimed at a box that
    // was stored lately so that hits, misses on distance and class all occur.
    function automatic t_track_word random_word(int unsigned spread);
        t_track_word t;
        int unsigned roll;
        int unsigned pick;
        roll      = $urandom_range(99);
        t.lost_id = ID_W'($urandom);
        t.box_x   = FIELD_W'($urandom);
        t.box_y   = FIELD_W'($urandom);
        t.box_w   = FIELD_W'($urandom);
        t.box_h   = FIELD_W'($urandom);
        if ($urandom_range(3) != 0) begin
            t.box_w = FIELD_W'($urandom_range(255));
            t.box_h = FIELD_W'($urandom_range(255));
        end
        t.obj_class = ($urandom_range(4) == 0) ? CLASS_W'($urandom) : CLASS_W'($urandom_range(3));
        if (roll < 45)
            t.cmd = CMD_STORE;
        else if (roll < 60)
            t.cmd = CMD_TICK;
        else if (roll < 90)
            t.cmd = CMD_QUERY;
        else
            t.cmd = CMD_NOP;
        if (t.cmd == CMD_STORE) begin
            recent_stores = {recent_stores, t};
            if (recent_stores.size() > DEPTH)
                void'(recent_stores.pop_front());
        end else if (t.cmd == CMD_QUERY && recent_stores.size() != 0
                     && $urandom_range(9) < 7) begin
            pick        = $urandom_range(recent_stores.size() - 1);
            t.obj_class = recent_stores[pick].obj_class;
            t.box_x     = nudge(recent_stores[pick].box_x, spread);
            t.box_y     = nudge(recent_stores[pick].box_y, spread);
            t.box_w     = recent_stores[pick].box_w;
            t.box_h     = recent_stores[pick].box_h;
        end
        return t;
    endfunction

    // Sender: hold a word until it is taken, then maybe idle, then the next one.
    always @(negedge i_clk) begin
        if (!drv_valid || words_taken == words_offered) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_word  <= pending_words.pop_front();
                drv_valid <= 1'b1;
                words_offered++;
            end else begin
                drv_valid <= 1'b0;
            end
        end
        rcv_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Monitor: predict on every taken word, check every result word.
    always @(posedge i_clk) begin
        t_track_result got;
        t_track_result want;
        t_track_result pred;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                pred = track_table_step(word_of(in_if.cmd, in_if.lost_id, in_if.box_x,
                                                in_if.box_y, in_if.box_w, in_if.box_h,
                                                in_if.obj_class));
                expected_results = {expected_results, pred};
                words_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got = '{found: out_if.found, match_id: out_if.match_id,
                        dropped: out_if.dropped, occupancy: out_if.occupancy};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result: found %b id %h dropped %b occ %0d",
                                 $realtime, got.found, got.match_id, got.dropped, got.occupancy);
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.match_id !== want.match_id
                        || got.dropped !== want.dropped || got.occupancy !== want.occupancy) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: exp/got found %b/%b id %h/%h drop %b/%b occ %0d/%0d",
                                     $realtime, want.found, got.found, want.match_id,
                                     got.match_id, want.dropped, got.dropped,
                                     want.occupancy, got.occupancy);
                    end
                end
            end
        end
    end

    // wait until every queued word is taken and every result has come back
    task automatic wait_for_drain();
        while (pending_words.size() != 0 || words_taken != words_offered
               || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // register write; only called with the block idle
    task automatic write_register(t_cfg_reg idx, logic [DLIM_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        if (idx == REG_MISSING_LIMIT)
            lim_missing = value[MLIM_W-1:0];
        else
            lim_distance = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One setting of the limits and the idling; the sender stops halfway
    // until the block has answered everything.
    task automatic run_phase(int unsigned mlim, int unsigned dlim, int unsigned src_pct,
                             int unsigned rcv_pct, int unsigned n_words, int unsigned spread);
        wait_for_drain();
        write_register(REG_MISSING_LIMIT, DLIM_W'(mlim));
        write_register(REG_DISTANCE_LIMIT, DLIM_W'(dlim));
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        for (int k = 0; k < n_words / 2; k++)
            queue_word(random_word(spread));
        wait_for_drain();
        for (int k = n_words / 2; k < n_words; k++)
            queue_word(random_word(spread));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset limits (30 frames, 50 pixels)
        src_idle_pct = 30;
        rcv_idle_pct = 75;
        queue_word(word_of(CMD_QUERY, 0, 10, 10, 4, 4, 0));   // empty table
        queue_word(word_of(CMD_NOP, 16'hFFFF, 4095, 4095, 4095, 4095, 255));
        queue_word(word_of(CMD_STORE, 16'hFFFF, 4095, 4095, 4095, 4095, 255));
        queue_word(word_of(CMD_STORE, 0, 0, 0, 0, 0, 0));
        queue_word(word_of(CMD_QUERY, 0, 4095, 4095, 4095, 4095, 255));
        queue_word(word_of(CMD_STORE, 1, 0, 0, 0, 0, 0));
        // exactly on the distance limit: hits the oldest of the two
        queue_word(word_of(CMD_QUERY, 0, 50, 0, 0, 0, 0));
        queue_word(word_of(CMD_QUERY, 0, 51, 0, 0, 0, 0));    // one past
        queue_word(word_of(CMD_QUERY, 0, 0, 0, 0, 0, 1));     // wrong class
        // fill the table, then one store too many
        for (int k = 0; k < 15; k++)
            queue_word(word_of(CMD_STORE, 100 + k, $urandom_range(4095),
                               $urandom_range(4095), 20, 20, 2));
        queue_word(word_of(CMD_STORE, 16'h5A5A, 1, 2, 3, 4, 7));
        queue_word(word_of(CMD_TICK, 0, 0, 0, 0, 0, 0));
        queue_word(word_of(CMD_NOP, 0, 0, 0, 0, 0, 0));

        // random part across the limit extremes and the idling regimes
        run_phase(0, 0, 30, 75, 200, 0);
        run_phase(255, 4095, 75, 30, 200, 100);
        run_phase(3, 20, 75, 30, 200, 25);
        run_phase(30, 50, 0, 0, 200, 60);

        wait_for_drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hdl/lrt_pkg.sv
hdl/lrt_ifs.sv
hdl/lrt_ctrl.sv
hdl/lrt_dp.sv
hdl/lost_track_recovery_table.sv
test/tb_lost_track_recovery_table.sv
